### sv/stq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted timer queue.
// No dependencies; used by stq_cell, stq_chain, sorted_timer_queue and tb_top.
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int ID_BITS    = 4;
  localparam int DELAY_BITS = 31;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_ACK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_STARTED   = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_FIRED     = 3'd2,
    KIND_DONE      = 3'd3,
    KIND_IDLE_TICK = 3'd4
  } kind_t;

  // One list entry as held by a cell
  typedef struct packed {
    logic                 valid;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] deadline;
  } entry_t;

  // Chain command, applied to all cells in the same cycle
  typedef struct packed {
    logic                 ins;   // sorted insert of (id, dl)
    logic                 pop;   // drop head, shift all left
    logic                 mark;  // start removal of entry with id
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] dl;
  } chain_ctl_t;

endpackage

### sv/sorted_timer_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted timer queue: command decode, clock, per-slot
// flags and output register. Depends on stq_pkg and stq_chain.
//
//  channel | dir | handshake        | contents
//  s_*     | in  | s_tvalid/tready  | tuser: command; tdata: timer_id, delay
//  m_*     | out | m_tvalid/tready  | tuser: kind; tdata: slot, now; tlast
//
// Start and acknowledge each give one beat.
// Cancel of a running timer gives its beat at once, then the hole left in
// the cell chain moves one cell per cycle to the tail; no new command is
// taken until that ends.
// Tick: the clock advances first, then one beat goes out per fired timer
// (or a single no-expiry beat). Sync reset, no clearing pass.
// A stalled output holds the FSM; input is taken only with the output free.
module sorted_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] command
  input  logic [39:0] s_tdata,   // [3:0] timer_id, [34:4] delay, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic [39:0] m_tdata,   // [3:0] slot, [35:4] now, rest zero
  output logic        m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TICK = 2'b10
  } state_t;

  state_t                             state, state_next;
  logic [stq_pkg::TIME_BITS-1:0]      clock, clock_next;
  logic [stq_pkg::NUM_TIMERS-1:0]     running, running_next;
  logic [stq_pkg::NUM_TIMERS-1:0]     pending, pending_next;

  stq_pkg::cmd_t                      in_cmd;
  logic [stq_pkg::ID_BITS-1:0]        in_id;
  logic [stq_pkg::DELAY_BITS-1:0]     in_delay;
  logic                               acc;
  logic                               out_free;

  stq_pkg::chain_ctl_t                ctl;
  stq_pkg::entry_t                    head, second;
  logic                               busy;
  logic                               head_due, second_due;

  logic                               out_load;
  stq_pkg::kind_t                     out_kind;
  logic [stq_pkg::ID_BITS-1:0]        out_slot;
  logic                               out_last;
  logic [stq_pkg::TIME_BITS-1:0]      out_now;

  assign in_cmd   = stq_pkg::cmd_t'(s_tuser);
  assign in_id    = s_tdata[3:0];
  assign in_delay = s_tdata[34:4];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && !busy && out_free;
  assign acc      = s_tvalid && s_tready;

  assign head_due   = head.valid && (head.deadline == clock);
  assign second_due = second.valid && (second.deadline == clock);

  stq_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .head   (head),
    .second (second),
    .busy   (busy)
  );

  always_comb begin
    state_next   = state;
    clock_next   = clock;
    running_next = running;
    pending_next = pending;
    ctl          = '0;
    ctl.id       = in_id;
    ctl.dl       = clock + stq_pkg::TIME_BITS'(in_delay);
    out_load     = 1'b0;
    out_kind     = stq_pkg::KIND_DONE;
    out_slot     = in_id;
    out_last     = 1'b1;
    out_now      = clock;

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            stq_pkg::CMD_TICK: begin
              clock_next = clock + 1'b1;
              state_next = ST_TICK;
            end
            stq_pkg::CMD_START: begin
              out_load = 1'b1;
              if (running[in_id] || pending[in_id]) begin
                out_kind = stq_pkg::KIND_REJECTED;
              end else if (in_delay == '0) begin
                pending_next[in_id] = 1'b1;
                out_kind            = stq_pkg::KIND_FIRED;
              end else begin
                running_next[in_id] = 1'b1;
                ctl.ins             = 1'b1;
                out_kind            = stq_pkg::KIND_STARTED;
              end
            end
            stq_pkg::CMD_CANCEL: begin
              out_load = 1'b1;
              out_kind = stq_pkg::KIND_DONE;
              if (running[in_id]) begin
                running_next[in_id] = 1'b0;
                ctl.mark            = 1'b1;
              end else begin
                pending_next[in_id] = 1'b0;
              end
            end
            stq_pkg::CMD_ACK: begin
              out_load            = 1'b1;
              out_kind            = stq_pkg::KIND_DONE;
              pending_next[in_id] = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (head_due) begin
            running_next[head.id] = 1'b0;
            pending_next[head.id] = 1'b1;
            ctl.pop               = 1'b1;
            out_kind              = stq_pkg::KIND_FIRED;
            out_slot              = head.id;
            out_last              = !second_due;
            if (!second_due) begin
              state_next = ST_IDLE;
            end
          end else begin
            out_kind   = stq_pkg::KIND_IDLE_TICK;
            out_slot   = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      clock    <= '0;
      running  <= '0;
      pending  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      clock   <= clock_next;
      running <= running_next;
      pending <= pending_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_kind;
      m_tdata <= {4'd0, out_now, out_slot};
      m_tlast <= out_last;
    end
  end

  // A timer never runs while its event is pending
  a_run_pend_excl: assert property (@(posedge clk) disable iff (rst)
    (running & pending) == '0)
    else $error("timer running with event pending");

  // Once a tick is fully handled, no due entry is left at the head
  a_no_stale_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !busy) |-> !head_due)
    else $error("due timer left at head of list");

  // Only a tick produces more than one beat
  a_multi_beat_tick: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (state == ST_TICK))
    else $error("non-final beat outside tick handling");

  // Chain compaction only follows a cancel
  a_busy_from_cancel: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(acc && in_cmd == stq_pkg::CMD_CANCEL))
    else $error("list compaction without cancel");

endmodule

### sv/stq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted timer list: holds a single entry and trades it
// with its neighbors. Depends on stq_pkg.
module stq_cell (
  input  logic               clk,
  input  logic               rst,
  input  stq_pkg::chain_ctl_t ctl,
  input  stq_pkg::entry_t    left,
  input  logic               left_k,
  input  logic               left_rm,
  input  stq_pkg::entry_t    right,
  output stq_pkg::entry_t    cur,
  output logic               k,
  output logic               rm
);

  logic [stq_pkg::TIME_BITS-1:0] diff;

  // Wrap-safe "own deadline strictly later than the new one"
  assign diff = cur.deadline - ctl.dl;
  assign k    = cur.valid && (diff != '0) && !diff[stq_pkg::TIME_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      rm        <= 1'b0;
    end else if (ctl.pop) begin
      cur <= right;
    end else if (ctl.ins) begin
      // later entries move right by one; the first later (or first free)
      // cell takes the new entry
      if (left_k) begin
        cur <= left;
      end else if (k || (!cur.valid && left.valid)) begin
        cur.valid    <= 1'b1;
        cur.id       <= ctl.id;
        cur.deadline <= ctl.dl;
      end
    end else if (ctl.mark) begin
      rm <= cur.valid && (cur.id == ctl.id);
    end else if (rm) begin
      // hole bubbles to the tail, one cell per cycle
      cur <= right;
      rm  <= 1'b0;
    end else if (left_rm) begin
      rm <= cur.valid;
    end
  end

endmodule

### sv/stq_chain.sv
`timescale 1ns / 1ps
// Row of stq_cell instances forming the sorted timer list.
// Depends on stq_pkg and stq_cell.
module stq_chain (
  input  logic                clk,
  input  logic                rst,
  input  stq_pkg::chain_ctl_t ctl,
  output stq_pkg::entry_t     head,
  output stq_pkg::entry_t     second,
  output logic                busy
);

  stq_pkg::entry_t                cells [stq_pkg::NUM_TIMERS];
  logic [stq_pkg::NUM_TIMERS-1:0] k;
  logic [stq_pkg::NUM_TIMERS-1:0] rm;

  genvar i;
  generate
    for (i = 0; i < stq_pkg::NUM_TIMERS; i++) begin : g_cell
      stq_pkg::entry_t left_e;
      stq_pkg::entry_t right_e;
      logic            left_k;
      logic            left_rm;

      if (i == 0) begin : g_first
        // front of list: a free head cell may always take a new entry
        always_comb begin
          left_e       = '0;
          left_e.valid = 1'b1;
        end
        assign left_k  = 1'b0;
        assign left_rm = 1'b0;
      end else begin : g_mid
        assign left_e  = cells[i-1];
        assign left_k  = k[i-1];
        assign left_rm = rm[i-1];
      end

      if (i == stq_pkg::NUM_TIMERS - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_notlast
        assign right_e = cells[i+1];
      end

      stq_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .left    (left_e),
        .left_k  (left_k),
        .left_rm (left_rm),
        .right   (right_e),
        .cur     (cells[i]),
        .k       (k[i]),
        .rm      (rm[i])
      );
    end
  endgenerate

  assign head   = cells[0];
  assign second = cells[1];
  assign busy   = |rm;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_timer_queue: drives tick, start, cancel and
// acknowledge beats and checks every report beat against a local timer list model.
// Depends on stq_pkg and the sorted_timer_queue RTL.
module tb_top;

  typedef struct {
    stq_pkg::kind_t kind;
    logic [3:0]     slot;
    logic [31:0]    now;
    logic           last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic [39:0] s_tdata = '0;   // [3:0] timer_id, [34:4] delay, rest zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [2:0]  m_tuser;        // [2:0] kind
  logic [39:0] m_tdata;        // [3:0] slot, [35:4] now, rest zero
  logic        m_tlast;

  sorted_timer_queue dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer model state
  logic [31:0] now_ticks = '0;
  logic [31:0] due_at[stq_pkg::NUM_TIMERS];
  bit          armed[stq_pkg::NUM_TIMERS];
  bit          flagged[stq_pkg::NUM_TIMERS];
  logic [3:0]  due_order[$];
  report_t     awaited_reports[$];

  int err_count = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold = 0;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // a strictly later than b, wrap-safe
  function automatic bit is_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && !d[31];
  endfunction

  function automatic void add_report(stq_pkg::kind_t k, logic [3:0] s);
    report_t r;
    r.kind = k;
    r.slot = s;
    r.now  = now_ticks;
    r.last = 1'b0;
    awaited_reports.push_back(r);
  endfunction

  function automatic void predict_reports(stq_pkg::cmd_t cmd, logic [3:0] id,
                                          logic [30:0] dly);
    int         n0;
    int         pos;
    logic [3:0] head;
    n0 = awaited_reports.size();
    case (cmd)
      stq_pkg::CMD_TICK: begin
        now_ticks = now_ticks + 1;
        while (due_order.size() > 0 && due_at[due_order[0]] == now_ticks) begin
          head = due_order.pop_front();
          armed[head]   = 1'b0;
          flagged[head] = 1'b1;
          add_report(stq_pkg::KIND_FIRED, head);
        end
        if (awaited_reports.size() == n0) add_report(stq_pkg::KIND_IDLE_TICK, 4'd0);
      end
      stq_pkg::CMD_START: begin
        if (armed[id] || flagged[id]) begin
          add_report(stq_pkg::KIND_REJECTED, id);
        end else if (dly == 0) begin
          flagged[id] = 1'b1;
          add_report(stq_pkg::KIND_FIRED, id);
        end else begin
          armed[id]  = 1'b1;
          due_at[id] = now_ticks + {1'b0, dly};
          pos = 0;
          // goes behind every timer due no later
          while (pos < due_order.size() && !is_later(due_at[due_order[pos]], due_at[id]))
            pos++;
          due_order.insert(pos, id);
          add_report(stq_pkg::KIND_STARTED, id);
        end
      end
      stq_pkg::CMD_CANCEL: begin
        if (!armed[id]) begin
          flagged[id] = 1'b0;
        end else begin
          for (pos = 0; pos < due_order.size(); pos++) begin
            if (due_order[pos] == id) begin
              due_order.delete(pos);
              break;
            end
          end
          armed[id] = 1'b0;
        end
        add_report(stq_pkg::KIND_DONE, id);
      end
      default: begin
        flagged[id] = 1'b0;
        add_report(stq_pkg::KIND_DONE, id);
      end
    endcase
    awaited_reports[awaited_reports.size()-1].last = 1'b1;
  endfunction

  // Called just after a rising edge; returns just after the edge that took the
  // beat, or after the trailing gap.
  task automatic send_command(stq_pkg::cmd_t cmd, logic [3:0] id, logic [30:0] dly);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'd0, dly, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_reports(cmd, id, dly);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off input until every report is back, then let a cancel clean-up finish
  task automatic drain_reports();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random slot in the wanted state: 0 idle, 1 running, 2 pending
  function automatic logic [3:0] pick_slot(int want);
    logic [3:0] cand[$];
    for (int i = 0; i < stq_pkg::NUM_TIMERS; i++) begin
      if ((want == 0 && !armed[i] && !flagged[i]) || (want == 1 && armed[i]) ||
          (want == 2 && flagged[i]))
        cand.push_back(i[3:0]);
    end
    if (cand.size() == 0) return 4'($urandom_range(0, stq_pkg::NUM_TIMERS - 1));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic test_directed();
    send_command(stq_pkg::CMD_TICK, 4'd0, 31'd0);            // no expiry
    send_command(stq_pkg::CMD_START, 4'd0, 31'd0);           // zero delay fires at once
    send_command(stq_pkg::CMD_START, 4'd0, 31'd5);           // refused: event pending
    send_command(stq_pkg::CMD_ACK, 4'd0, 31'h7FFF_FFFF);
    send_command(stq_pkg::CMD_START, 4'd15, 31'h7FFF_FFFF);  // farthest deadline
    send_command(stq_pkg::CMD_START, 4'd15, 31'd1);          // refused: running
    send_command(stq_pkg::CMD_ACK, 4'd15, 31'd0);            // ack on a running slot
    send_command(stq_pkg::CMD_START, 4'd1, 31'd2);
    send_command(stq_pkg::CMD_START, 4'd2, 31'd2);
    send_command(stq_pkg::CMD_START, 4'd3, 31'd1);
    send_command(stq_pkg::CMD_CANCEL, 4'd2, 31'd0);          // pull from the middle
    send_command(stq_pkg::CMD_TICK, 4'd0, 31'd0);
    send_command(stq_pkg::CMD_TICK, 4'd0, 31'd0);
    send_command(stq_pkg::CMD_CANCEL, 4'd1, 31'd0);          // clears pending event
    send_command(stq_pkg::CMD_CANCEL, 4'd4, 31'd0);          // idle slot
    send_command(stq_pkg::CMD_ACK, 4'd5, 31'd0);             // idle slot
    // equal deadlines fire together in start order
    send_command(stq_pkg::CMD_START, 4'd7, 31'd1);
    send_command(stq_pkg::CMD_START, 4'd4, 31'd1);
    send_command(stq_pkg::CMD_START, 4'd6, 31'd1);
    send_command(stq_pkg::CMD_START, 4'd5, 31'd1);
    send_command(stq_pkg::CMD_TICK, 4'd0, 31'd0);
    send_command(stq_pkg::CMD_CANCEL, 4'd15, 31'd0);         // tail of the list
    send_command(stq_pkg::CMD_ACK, 4'd3, 31'd0);
    drain_reports();
  endtask

  // every slot running at once, then drained by ticks
  task automatic test_full_list();
    for (int i = 0; i < stq_pkg::NUM_TIMERS; i++) begin
      if (flagged[i]) send_command(stq_pkg::CMD_ACK, i[3:0], 31'($urandom()));
      send_command(stq_pkg::CMD_START, i[3:0], 31'($urandom_range(1, 5)));
    end
    send_command(stq_pkg::CMD_START, 4'd9, 31'd3);           // refused
    send_command(stq_pkg::CMD_CANCEL, 4'($urandom_range(0, 15)), 31'd0);
    while (due_order.size() > 0) send_command(stq_pkg::CMD_TICK, 4'd0, 31'($urandom()));
    drain_reports();
  endtask

  task automatic test_random(int count);
    int         r;
    logic [30:0] dly;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      if (n == count / 2) drain_reports();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_command(stq_pkg::CMD_TICK, 4'($urandom_range(0, 15)), 31'($urandom()));
      end else if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 15) dly = 31'd0;
        else if (r < 85) dly = 31'($urandom_range(1, 12));
        else if (r < 95) dly = 31'($urandom_range(13, 300));
        else dly = 31'($urandom());
        send_command(stq_pkg::CMD_START, ($urandom_range(0, 4) != 0) ? pick_slot(0) :
                     4'($urandom_range(0, 15)), dly);
      end else if (r < 85) begin
        send_command(stq_pkg::CMD_CANCEL, ($urandom_range(0, 4) < 3) ? pick_slot(1) :
                     4'($urandom_range(0, 15)), 31'($urandom()));
      end else begin
        send_command(stq_pkg::CMD_ACK, ($urandom_range(0, 9) < 7) ? pick_slot(2) :
                     4'($urandom_range(0, 15)), 31'($urandom()));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // report sink with random back-pressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected report beat: kind %0d slot %0d", m_tuser, m_tdata[3:0]);
        err_count++;
      end else begin
        report_t e;
        e = awaited_reports.pop_front();
        if (m_tuser != e.kind) begin
          $error("kind mismatch: expected %0d, got %0d", e.kind, m_tuser);
          err_count++;
        end
        if (m_tdata[3:0] != e.slot) begin
          $error("slot mismatch: expected %0d, got %0d", e.slot, m_tdata[3:0]);
          err_count++;
        end
        if (m_tdata[35:4] != e.now) begin
          $error("now mismatch: expected %0d, got %0d", e.now, m_tdata[35:4]);
          err_count++;
        end
        if (m_tlast != e.last) begin
          $error("last mismatch: expected %0d, got %0d", e.last, m_tlast);
          err_count++;
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      rx_hold = gap_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    for (int i = 0; i < stq_pkg::NUM_TIMERS; i++) begin
      armed[i]   = 1'b0;
      flagged[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_random(420);
    drain_reports();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
